### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the requantizer modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property must hold at every clock edge outside reset
`define NSR_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define NSR_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define NSR_ASSERT(name, clk, rst_n, prop, msg)
`define NSR_NEVER(name, clk, rst_n, expr, msg)
`endif

`endif

### hdl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// shared constants, types and tables of the noise shaping requantizer
// ----------------------------------------------------------------------------
`default_nettype none

package nsr_pkg;

    localparam int CHANNELS    = 2;
    localparam int CH_W        = 1;
    localparam int MAX_OS      = 16;
    localparam int L_W         = 5;
    localparam int MAX_TAPS    = 9;
    localparam int TAP_W       = 4;
    localparam int SAMPLE_BITS = 24;
    localparam int Q_W         = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int DIV_N_W     = 48;
    localparam int DIV_D_W     = 40;
    localparam int DIV_CNT_W   = 6;
    localparam int DRAW_W      = 4;

    localparam logic [31:0] LFSR_MASK = 32'hD000_0001;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OVERSAMPLING = 2'd0,
        CFG_QUANT_STEP   = 2'd1,
        CFG_DITHER_MODE  = 2'd2,
        CFG_SHAPING_SET  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DITH_NONE = 2'd0,
        DITH_RECT = 2'd1,
        DITH_TRI  = 2'd2,
        DITH_HP   = 2'd3
    } dith_mode_t;

    typedef enum logic [1:0] {
        DIV_INTERP = 2'd0,
        DIV_QUANT  = 2'd1,
        DIV_MEAN   = 2'd2
    } div_op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_PT_MUL, S_PT_GO, S_PT_WAIT, S_PT_SUM,
        S_FB_MUL, S_FB_ACC, S_FB_RND, S_FB_SUB,
        S_DRAW1, S_CAP, S_DRAW2, S_DITH,
        S_Q_MUL, S_Q_NUM, S_Q_GO, S_Q_WAIT, S_Q_PROD, S_Q_Y, S_ERR,
        S_MEAN_GO, S_MEAN_WAIT, S_MEAN_SAT, S_OUT
    } state_t;

    typedef struct packed {
        logic    accept;
        logic    diffk_load;
        logic    div_start;
        div_op_t div_op;
        logic    point_load;
        logic    fb_mul;
        logic    fb_acc;
        logic    fb_rnd;
        logic    fb_sub;
        logic    lfsr_step;
        logic    u1_cap;
        logic    dith_load;
        logic    dq_load;
        logic    num_load;
        logic    yprod_load;
        logic    y_load;
        logic    err_commit;
        logic    mean_load;
        logic    out_load;
    } nsr_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       taps_zero;
        logic       tap_last;
        logic       draw_last;
        logic       point_last;
        dith_mode_t dith_mode;
    } nsr_status_t;

    // filter order of a shaping set, zero for none or unused codes
    function automatic logic [TAP_W-1:0] shaping_taps(input logic [2:0] set);
        logic [TAP_W-1:0] n;
        unique case (set)
            3'd1:    n = TAP_W'(1);
            3'd2:    n = TAP_W'(2);
            3'd3:    n = TAP_W'(3);
            3'd4:    n = TAP_W'(5);
            3'd5:    n = TAP_W'(9);
            default: n = '0;
        endcase
        return n;
    endfunction

    // q4.12 feedback coefficients
    function automatic logic signed [15:0] shaping_coef(input logic [2:0] set,
                                                         input logic [TAP_W-1:0] tap);
        logic signed [15:0] row [MAX_TAPS];
        row = '{default: 16'sd0};
        unique case (set)
            3'd1: row = '{16'sd4096, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
                          16'sd0, 16'sd0, 16'sd0, 16'sd0};
            3'd2: row = '{16'sd8192, -16'sd4096, 16'sd0, 16'sd0, 16'sd0,
                          16'sd0, 16'sd0, 16'sd0, 16'sd0};
            3'd3: row = '{16'sd6648, -16'sd4022, 16'sd446, 16'sd0, 16'sd0,
                          16'sd0, 16'sd0, 16'sd0, 16'sd0};
            3'd4: row = '{16'sd8327, -16'sd8868, 16'sd8024, -16'sd6513, 16'sd2519,
                          16'sd0, 16'sd0, 16'sd0, 16'sd0};
            3'd5: row = '{16'sd9880, -16'sd13804, 16'sd16126, -16'sd17097, 16'sd13734,
                          -16'sd9032, 16'sd5247, -16'sd2331, 16'sd347};
            default: row = '{default: 16'sd0};
        endcase
        return (tap < TAP_W'(MAX_TAPS)) ? row[tap] : 16'sd0;
    endfunction

endpackage

`default_nettype wire

### hdl/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsr_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [nsr_pkg::DIV_N_W-1:0]  dividend,
    input  logic [nsr_pkg::DIV_D_W-1:0]  divisor,
    output logic [nsr_pkg::DIV_N_W-1:0]  quotient,
    output logic                         busy,
    output logic                         done
);
    import nsr_pkg::*;

    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W:0]     trial;
    logic                 fits;

    always_comb begin
        shifted   = {rem_reg, quo_reg[DIV_N_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        fits      = shifted >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? trial[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_N_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            dsr_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

    `NSR_ASSERT(a_start_runs, aclk, aresetn, start |=> busy_reg && !done_reg, "divider did not start")

endmodule

`default_nettype wire

### hdl/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl
// sequencer: steps the datapath through points, taps, draws and divisions
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  nsr_pkg::nsr_status_t status,
    output nsr_pkg::nsr_cmd_t    cmd
);
    import nsr_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   div_wait;

    assign out_free = !m_valid_reg || m_ready;

    // states that wait on the divider
    assign div_wait = (state_reg == S_PT_WAIT) || (state_reg == S_Q_WAIT) ||
                      (state_reg == S_MEAN_WAIT);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_PT_MUL;
            S_PT_MUL:    state_next = S_PT_GO;
            S_PT_GO:     state_next = S_PT_WAIT;
            S_PT_WAIT:   if (status.div_done) state_next = S_PT_SUM;
            S_PT_SUM:    state_next = status.taps_zero ? S_FB_RND : S_FB_MUL;
            S_FB_MUL:    state_next = S_FB_ACC;
            S_FB_ACC:    state_next = status.tap_last ? S_FB_RND : S_FB_MUL;
            S_FB_RND:    state_next = S_FB_SUB;
            S_FB_SUB:    state_next = (status.dith_mode == DITH_NONE) ? S_DITH : S_DRAW1;
            S_DRAW1: begin
                if (status.draw_last) begin
                    state_next = (status.dith_mode == DITH_TRI) ? S_CAP : S_DITH;
                end
            end
            S_CAP:       state_next = S_DRAW2;
            S_DRAW2:     if (status.draw_last) state_next = S_DITH;
            S_DITH:      state_next = S_Q_MUL;
            S_Q_MUL:     state_next = S_Q_NUM;
            S_Q_NUM:     state_next = S_Q_GO;
            S_Q_GO:      state_next = S_Q_WAIT;
            S_Q_WAIT:    if (status.div_done) state_next = S_Q_PROD;
            S_Q_PROD:    state_next = S_Q_Y;
            S_Q_Y:       state_next = S_ERR;
            S_ERR:       state_next = status.point_last ? S_MEAN_GO : S_PT_MUL;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (status.div_done) state_next = S_MEAN_SAT;
            S_MEAN_SAT:  state_next = S_OUT;
            S_OUT:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        cmd        = '0;
        cmd.div_op = DIV_INTERP;
        unique case (state_reg)
            S_IDLE:      cmd.accept = s_valid;
            S_PT_MUL:    cmd.diffk_load = 1'b1;
            S_PT_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_INTERP;
            end
            S_PT_SUM:    cmd.point_load = 1'b1;
            S_FB_MUL:    cmd.fb_mul = 1'b1;
            S_FB_ACC:    cmd.fb_acc = 1'b1;
            S_FB_RND:    cmd.fb_rnd = 1'b1;
            S_FB_SUB:    cmd.fb_sub = 1'b1;
            S_DRAW1:     cmd.lfsr_step = 1'b1;
            S_CAP:       cmd.u1_cap = 1'b1;
            S_DRAW2:     cmd.lfsr_step = 1'b1;
            S_DITH:      cmd.dith_load = 1'b1;
            S_Q_MUL:     cmd.dq_load = 1'b1;
            S_Q_NUM:     cmd.num_load = 1'b1;
            S_Q_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_QUANT;
            end
            S_Q_PROD:    cmd.yprod_load = 1'b1;
            S_Q_Y:       cmd.y_load = 1'b1;
            S_ERR:       cmd.err_commit = 1'b1;
            S_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_op    = DIV_MEAN;
            end
            S_MEAN_SAT:  cmd.mean_load = 1'b1;
            S_OUT:       cmd.out_load = out_free;
            default:     cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    `NSR_ASSERT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready |=> m_valid_reg, "beat dropped")
    `NSR_NEVER(a_done_in_wait, aclk, aresetn, status.div_done && !div_wait, "stray divider done")

endmodule

`default_nettype wire

### hdl/nsr_datapath.sv
// ----------------------------------------------------------------------------
// nsr_datapath
// channel state, feedback filter, dither source, rounding and divider
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module nsr_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_we,
    input  logic [nsr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    input  logic [nsr_pkg::CH_W-1:0]               s_channel,
    input  logic signed [nsr_pkg::SAMPLE_BITS-1:0] s_sample_in,
    output logic signed [nsr_pkg::SAMPLE_BITS-1:0] m_sample_out,
    input  nsr_pkg::nsr_cmd_t                      cmd,
    output nsr_pkg::nsr_status_t                   status
);
    import nsr_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
        if (a > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (a < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return a[31:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_out(input logic signed [63:0] a);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd1 <<< (SAMPLE_BITS - 1);
        lo = -hi;
        hi = hi - 64'sd1;
        if (a > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (a < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return a[SAMPLE_BITS-1:0];
    endfunction

    // configuration
    logic [L_W-1:0]  os_reg;
    logic [Q_W-1:0]  q_reg;
    dith_mode_t      mode_reg;
    logic [2:0]      set_reg;
    logic [L_W-1:0]  l_eff;
    logic [Q_W-1:0]  q_eff;
    logic [TAP_W-1:0] taps;

    // channel state
    logic signed [SAMPLE_BITS-1:0] prev_sample_reg [CHANNELS];
    logic signed [16:0]            prev_dither_reg [CHANNELS];
    logic signed [31:0]            err_hist_reg    [CHANNELS][MAX_TAPS];
    logic [31:0]                   lfsr_reg, lfsr_next;

    // counters
    logic [L_W-1:0]    k_reg;
    logic [TAP_W-1:0]  tap_reg;
    logic [DRAW_W-1:0] draw_cnt_reg;

    // per-item and per-point working registers
    logic [CH_W-1:0]               ch_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, prev_reg;
    logic signed [29:0]            diffk_reg, diffk_next;
    logic signed [25:0]            point_reg, point_next;
    logic signed [47:0]            prod_reg, prod_next;
    logic signed [51:0]            acc_reg, acc_next;
    logic [39:0]                   fb_mag_reg, fb_mag_next;
    logic                          fb_neg_reg;
    logic signed [31:0]            v_reg, v_next;
    logic [15:0]                   u1_reg;
    logic signed [16:0]            d_reg, d_next;
    logic signed [16:0]            rect;
    logic signed [41:0]            dq_reg, dq_next;
    logic signed [48:0]            num_reg, num_next;
    logic signed [58:0]            yprod_reg, yprod_next;
    logic signed [31:0]            y_reg, y_next;
    logic signed [31:0]            err_next;
    logic signed [36:0]            total_reg, total_next;
    logic signed [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    // divider interface
    logic signed [48:0]   div_n;
    logic [DIV_N_W-1:0]   div_r;
    logic [DIV_N_W-1:0]   div_dividend;
    logic [DIV_D_W-1:0]   div_divisor;
    logic [DIV_N_W-1:0]   div_quotient;
    logic                 div_busy, div_done;
    logic                 div_neg_reg;
    logic signed [48:0]   quo_s;
    logic [48:0]          quo_ext;

    logic signed [24:0]   diff;
    logic [51:0]          acc_u;
    logic [51:0]          acc_rnd;
    logic signed [41:0]   pt_ext, fb_ext, v_wide;
    logic signed [24:0]   q_s;
    logic [48:0]          n_u;

    always_comb begin
        if (os_reg == '0) begin
            l_eff = L_W'(1);
        end else if (os_reg > L_W'(MAX_OS)) begin
            l_eff = L_W'(MAX_OS);
        end else begin
            l_eff = os_reg;
        end
        q_eff = (q_reg == '0) ? Q_W'(1) : q_reg;
        taps  = shaping_taps(set_reg);
        q_s   = $signed({1'b0, q_eff});
    end

    // divider operands: magnitude plus half divisor, in one adder
    always_comb begin
        unique case (cmd.div_op)
            DIV_QUANT: begin
                div_n       = num_reg;
                div_r       = DIV_N_W'({q_eff, 15'h0});
                div_divisor = {q_eff, 16'h0};
            end
            DIV_MEAN: begin
                div_n       = 49'(total_reg);
                div_r       = DIV_N_W'(l_eff >> 1);
                div_divisor = DIV_D_W'(l_eff);
            end
            default: begin
                div_n       = 49'(diffk_reg);
                div_r       = DIV_N_W'(l_eff >> 1);
                div_divisor = DIV_D_W'(l_eff);
            end
        endcase
        n_u = div_n;
        div_dividend = div_n[48] ? (~n_u[DIV_N_W-1:0] + div_r + DIV_N_W'(1))
                                 : (n_u[DIV_N_W-1:0] + div_r);
        quo_ext = {1'b0, div_quotient};
        quo_s   = div_neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
    end

    nsr_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    // arithmetic
    always_comb begin
        diff       = 25'(x_reg) - 25'(prev_reg);
        diffk_next = 30'(diff) * 30'($signed({1'b0, k_reg}));
        point_next = 26'(prev_reg) + $signed(quo_s[25:0]);
        prod_next  = 48'(shaping_coef(set_reg, tap_reg)) * 48'(err_hist_reg[ch_reg][tap_reg]);
        acc_next   = acc_reg + 52'(prod_reg);
        acc_u      = acc_reg;
        acc_rnd    = acc_reg[51] ? (~acc_u + 52'd2049) : (acc_u + 52'd2048);
        fb_mag_next = acc_rnd[51:12];
        pt_ext     = 42'(point_reg);
        fb_ext     = $signed({2'b00, fb_mag_reg});
        v_wide     = fb_neg_reg ? (pt_ext + fb_ext) : (pt_ext - fb_ext);
        v_next     = sat32(64'(v_wide));
        rect       = $signed({1'b0, lfsr_reg[15:0]}) - 17'sd32768;
        unique case (mode_reg)
            DITH_RECT: d_next = rect;
            DITH_TRI:  d_next = $signed({1'b0, u1_reg}) - $signed({1'b0, lfsr_reg[15:0]});
            DITH_HP:   d_next = rect - prev_dither_reg[ch_reg];
            default:   d_next = '0;
        endcase
        dq_next    = 42'(d_reg) * 42'(q_s);
        num_next   = 49'($signed({v_reg, 16'h0})) + 49'(dq_reg);
        yprod_next = 59'($signed(quo_s[33:0])) * 59'(q_s);
        y_next     = sat32(64'(yprod_reg));
        err_next   = sat32(64'(33'(y_reg) - 33'(v_reg)));
        total_next = total_reg + 37'(y_reg);
        mean_next  = sat_out(64'(quo_s));
        lfsr_next  = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    end

    // state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            os_reg       <= L_W'(1);
            q_reg        <= Q_W'(2097152);
            mode_reg     <= DITH_NONE;
            set_reg      <= '0;
            lfsr_reg     <= LFSR_SEED;
            k_reg        <= '0;
            tap_reg      <= '0;
            draw_cnt_reg <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                prev_sample_reg[c] <= '0;
                prev_dither_reg[c] <= '0;
                for (int t = 0; t < MAX_TAPS; t++) begin
                    err_hist_reg[c][t] <= '0;
                end
            end
        end else begin
            if (cfg_we) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_OVERSAMPLING: os_reg   <= cfg_wdata[L_W-1:0];
                    CFG_QUANT_STEP:   q_reg    <= cfg_wdata[Q_W-1:0];
                    CFG_DITHER_MODE:  mode_reg <= dith_mode_t'(cfg_wdata[1:0]);
                    CFG_SHAPING_SET:  set_reg  <= cfg_wdata[2:0];
                    default:          set_reg  <= set_reg;
                endcase
            end
            if (cmd.accept) begin
                prev_sample_reg[s_channel] <= s_sample_in;
                k_reg        <= '0;
                draw_cnt_reg <= '0;
            end
            if (cmd.point_load) begin
                tap_reg <= '0;
            end
            if (cmd.fb_acc) begin
                tap_reg <= tap_reg + TAP_W'(1);
            end
            if (cmd.lfsr_step) begin
                lfsr_reg     <= lfsr_next;
                draw_cnt_reg <= draw_cnt_reg + DRAW_W'(1);
            end
            if (cmd.dith_load && (mode_reg == DITH_HP)) begin
                prev_dither_reg[ch_reg] <= rect;
            end
            if (cmd.err_commit) begin
                k_reg <= k_reg + L_W'(1);
                for (int t = MAX_TAPS - 1; t > 0; t--) begin
                    err_hist_reg[ch_reg][t] <= err_hist_reg[ch_reg][t-1];
                end
                err_hist_reg[ch_reg][0] <= err_next;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            ch_reg    <= s_channel;
            x_reg     <= s_sample_in;
            prev_reg  <= prev_sample_reg[s_channel];
            total_reg <= '0;
        end
        if (cmd.diffk_load) diffk_reg <= diffk_next;
        if (cmd.div_start)  div_neg_reg <= div_n[48];
        if (cmd.point_load) begin
            point_reg <= point_next;
            acc_reg   <= '0;
        end
        if (cmd.fb_mul) prod_reg <= prod_next;
        if (cmd.fb_acc) acc_reg <= acc_next;
        if (cmd.fb_rnd) begin
            fb_mag_reg <= fb_mag_next;
            fb_neg_reg <= acc_reg[51];
        end
        if (cmd.fb_sub)     v_reg     <= v_next;
        if (cmd.u1_cap)     u1_reg    <= lfsr_reg[15:0];
        if (cmd.dith_load)  d_reg     <= d_next;
        if (cmd.dq_load)    dq_reg    <= dq_next;
        if (cmd.num_load)   num_reg   <= num_next;
        if (cmd.yprod_load) yprod_reg <= yprod_next;
        if (cmd.y_load)     y_reg     <= y_next;
        if (cmd.err_commit) total_reg <= total_next;
        if (cmd.mean_load)  mean_reg  <= mean_next;
        if (cmd.out_load)   out_reg   <= mean_reg;
    end

    always_comb begin
        status.div_done   = div_done;
        status.taps_zero  = (taps == '0);
        status.tap_last   = (tap_reg == taps - TAP_W'(1));
        status.draw_last  = (draw_cnt_reg == {DRAW_W{1'b1}});
        status.point_last = (k_reg == l_eff - L_W'(1));
        status.dith_mode  = mode_reg;
    end

    assign m_sample_out = out_reg;

    `NSR_ASSERT(a_div_free, aclk, aresetn, cmd.div_start |-> !div_busy, "divider restarted while busy")

endmodule

`default_nettype wire

### hdl/noise_shaping_requantizer.sv
// ----------------------------------------------------------------------------
// noise_shaping_requantizer
// per-channel error-feedback requantizer with dither and oversampling
// ----------------------------------------------------------------------------
// usage:
//  - input channel s_valid/s_ready carries a channel number and a signed
//    q1.23 sample; one result beat on m_valid/m_ready per input beat
//  - cfg_we writes register cfg_index (0 oversampling, 1 step, 2 dither mode,
//    3 shaping set) from cfg_wdata; write only while idle
//  - one item at a time: s_ready is high only in the idle state
//  - each of the L points runs the interpolation division, the feedback taps
//    and the dither draws (none without dither, one, or two and a capture
//    for triangular), then the quantization division; each division holds
//    the sequencer until it is done
//  - the final mean of the L points takes one more division
//  - the result sits in an output register; the next item is taken while it
//    waits, and the block stalls only once that next result is also ready
//  - reset clears configuration to defaults, all channel history to zero
//    and seeds the dither lfsr with one; no clearing pass is needed
// ----------------------------------------------------------------------------
`default_nettype none

module noise_shaping_requantizer (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_we,
    input  logic [nsr_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [nsr_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // input beats
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [nsr_pkg::CH_W-1:0]               s_channel,
    input  logic signed [nsr_pkg::SAMPLE_BITS-1:0] s_sample_in,
    // result beats
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [nsr_pkg::SAMPLE_BITS-1:0] m_sample_out
);
    import nsr_pkg::*;

    nsr_cmd_t    cmd;
    nsr_status_t status;

    // sequencer: one state per arithmetic step, waits on the divider
    nsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: configuration, channel history, lfsr, multiplier, divider
    nsr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_channel    (s_channel),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

### sim/tb_noise_shaping_requantizer.sv
// ----------------------------------------------------------------------------
// tb_noise_shaping_requantizer
// self-checking bench: a scoreboard predicts every averaged requantized
// sample from its own copy of channel history, dither lfsr and registers
// ----------------------------------------------------------------------------
`default_nettype none

module tb_noise_shaping_requantizer;
    timeunit 1ns;
    timeprecision 1ps;

    import nsr_pkg::*;

    // scoreboard: requantizer prediction plus queue of expected samples
    class requant_scoreboard;
        int unsigned osf;
        logic [23:0] step;
        dith_mode_t  dmode;
        logic [2:0]  sset;
        int          prev_smp [CHANNELS];
        int          err_hist [CHANNELS][MAX_TAPS];
        int          prev_dith [CHANNELS];
        logic [31:0] lfsr;
        logic [23:0] pending_samples [$];
        int          mismatches;
        int          beats_in;
        int          beats_out;

        function new();
            osf = 1;
            step = 24'd2097152;
            dmode = DITH_NONE;
            sset = 3'd0;
            foreach (prev_smp[c]) begin
                prev_smp[c] = 0;
                prev_dith[c] = 0;
                for (int t = 0; t < MAX_TAPS; t++) err_hist[c][t] = 0;
            end
            lfsr = 32'h1;
            mismatches = 0;
            beats_in = 0;
            beats_out = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [23:0] val);
            case (idx)
                CFG_OVERSAMPLING: osf = val[4:0];
                CFG_QUANT_STEP:   step = val;
                CFG_DITHER_MODE:  dmode = dith_mode_t'(val[1:0]);
                CFG_SHAPING_SET:  sset = val[2:0];
            endcase
        endfunction

        function longint sat(longint v, int bits);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) return hi;
            if (v < lo) return lo;
            return v;
        endfunction

        // divide, rounding half away from zero
        function longint rdiv(longint n, longint d);
            longint mag;
            longint r;
            mag = (n < 0) ? -n : n;
            r = (mag + d / 2) / d;
            return (n < 0) ? -r : r;
        endfunction

        function int draw16();
            for (int i = 0; i < 16; i++) begin
                if (lfsr[0]) lfsr = (lfsr >> 1) ^ 32'hD000_0001;
                else lfsr = lfsr >> 1;
            end
            return int'(lfsr[15:0]);
        endfunction

        function int next_dither(int ch);
            int r;
            int d;
            case (dmode)
                DITH_RECT: return draw16() - 32768;
                DITH_TRI: begin
                    r = draw16();
                    return r - draw16();
                end
                DITH_HP: begin
                    r = draw16() - 32768;
                    d = r - prev_dith[ch];
                    prev_dith[ch] = r;
                    return d;
                end
                default: return 0;
            endcase
        endfunction

        function int coef(int set, int tap);
            int rows [5][9] = '{
                '{4096, 0, 0, 0, 0, 0, 0, 0, 0},
                '{8192, -4096, 0, 0, 0, 0, 0, 0, 0},
                '{6648, -4022, 446, 0, 0, 0, 0, 0, 0},
                '{8327, -8868, 8024, -6513, 2519, 0, 0, 0, 0},
                '{9880, -13804, 16126, -17097, 13734, -9032, 5247, -2331, 347}};
            return rows[set - 1][tap];
        endfunction

        function void note_input(logic [0:0] ch_in, logic signed [23:0] smp);
            int ch;
            longint x, prev, q, total, point, fb, v, m, y, e;
            int unsigned l;
            int taps;
            int d;
            int orders [5] = '{1, 2, 3, 5, 9};
            ch = int'(ch_in) % CHANNELS;
            x = smp;
            prev = prev_smp[ch];
            l = (osf == 0) ? 1 : (osf > MAX_OS) ? MAX_OS : osf;
            q = (step == 0) ? 1 : longint'(step);
            taps = (sset >= 1 && sset <= 5) ? orders[sset - 1] : 0;
            total = 0;
            for (int k = 0; k < l; k++) begin
                point = prev + rdiv((x - prev) * k, l);
                fb = 0;
                for (int i = 0; i < taps; i++)
                    fb += longint'(coef(sset, i)) * longint'(err_hist[ch][i]);
                v = sat(point - rdiv(fb, 4096), 32);
                d = next_dither(ch);
                m = rdiv(v * 65536 + longint'(d) * q, q * 65536);
                y = sat(m * q, 32);
                e = sat(y - v, 32);
                for (int i = MAX_TAPS - 1; i > 0; i--) err_hist[ch][i] = err_hist[ch][i - 1];
                err_hist[ch][0] = int'(e);
                total += y;
            end
            prev_smp[ch] = int'(x);
            pending_samples.push_back(24'(sat(rdiv(total, l), 24)));
            beats_in++;
        endfunction

        function void check_result(logic [23:0] got);
            logic [23:0] want;
            beats_out++;
            if (pending_samples.size() == 0) begin
                $error("sample_out: no expectation waiting, actual %0d", $signed(got));
                mismatches++;
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want) begin
                $error("sample_out: expected %0d actual %0d", $signed(want), $signed(got));
                mismatches++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_we = 1'b0;
    logic [1:0]        cfg_index = '0;
    logic [23:0]       cfg_wdata = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [0:0]        s_channel = '0;
    logic signed [23:0] s_sample_in = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic signed [23:0] m_sample_out;

    requant_scoreboard sb = new();
    bit                hold_req = 1'b0;
    int                cfg_writes = 0;

    noise_shaping_requantizer i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_channel    (s_channel),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // beats are taken on pre-edge values, so no ordering race with the dut
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_input(s_channel, s_sample_in);
        if (aresetn && m_valid && m_ready) sb.check_result(m_sample_out);
    end

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 200);
    endfunction

    // one write, then write enable drops so that it is low between writes
    task automatic cfg_write(cfg_idx_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
        @(posedge aclk);
    endtask

    task automatic set_all(logic [4:0] os, logic [23:0] q, logic [1:0] dm, logic [2:0] ss);
        cfg_write(CFG_OVERSAMPLING, 24'(os));
        cfg_write(CFG_QUANT_STEP, q);
        cfg_write(CFG_DITHER_MODE, 24'(dm));
        cfg_write(CFG_SHAPING_SET, 24'(ss));
    endtask

    // one input beat; valid held until accepted, dropped only for a gap
    task automatic send_sample(logic [0:0] ch, logic signed [23:0] smp);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_channel   <= ch;
        s_sample_in <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // block goes idle once every expected sample has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [23:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'h7FFFFF;
        if (r == 1) return 24'h800000;
        if (r == 2) return 24'(int'($urandom_range(0, 64)) - 32);
        return 24'($urandom);
    endfunction

    // receiver: random m_ready, plus one long hold-off on request
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (6000) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // stimulus
    initial begin
        logic [4:0] os;
        logic [23:0] q;
        int r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, field extremes on both channels
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'h000000);
        send_sample(1'b1, 24'hFFFFFF);
        send_sample(1'b0, 24'h000001);
        send_sample(1'b1, 24'h7FFFFF);
        drain();

        // oversampling zero, step zero, unused shaping code
        set_all(5'd0, 24'd0, DITH_NONE, 3'd7);
        send_sample(1'b0, 24'h123456);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'hFFFFFF);
        drain();

        // oversampling above the maximum, largest step, highpass, order nine
        set_all(5'd31, 24'hFFFFFF, DITH_HP, 3'd5);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b0, 24'h800000);
        drain();

        // full-scale step, triangular, order five
        set_all(5'd16, 24'd8388608, DITH_TRI, 3'd4);
        send_sample(1'b1, 24'h400000);
        send_sample(1'b0, 24'hC00000);
        drain();

        // smallest step, rectangular then no dither, orders one to three with kept history
        set_all(5'd2, 24'd1, DITH_RECT, 3'd1);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b0, 24'h800000);
        drain();
        cfg_write(CFG_SHAPING_SET, 24'd2);
        send_sample(1'b1, 24'h00ABCD);
        send_sample(1'b0, 24'h7FFFFF);
        drain();
        cfg_write(CFG_SHAPING_SET, 24'd3);
        cfg_write(CFG_DITHER_MODE, 24'(DITH_NONE));
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'h333333);
        send_sample(1'b1, 24'hFFFFFF);
        drain();

        // random phases, mostly small oversampling to keep runs short
        for (int p = 0; p < 14; p++) begin
            r = $urandom_range(0, 9);
            os = (r < 7) ? 5'($urandom_range(0, 4)) : (r < 9) ? 5'($urandom_range(5, 12))
                                                              : 5'($urandom_range(13, 31));
            r = $urandom_range(0, 5);
            q = (r == 0) ? 24'($urandom_range(0, 3)) : (r == 1) ? 24'hFFFFFF
                 : (r == 2) ? 24'(1 << $urandom_range(0, 23)) : 24'($urandom);
            set_all(os, q, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)));
            if (p == 3) hold_req = 1'b1;   // sender keeps offering into a stalled output
            for (int i = 0; i < 38; i++) send_sample(1'($urandom), rand_sample());
            drain();
        end

        repeat (100) @(posedge aclk);
        $display("covered %0d input beats, %0d results, %0d register writes",
                 sb.beats_in, sb.beats_out, cfg_writes);
        if (sb.pending_samples.size() != 0) begin
            $error("sample_out: %0d expectations left over", sb.pending_samples.size());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("tb_noise_shaping_requantizer: clean");
        end else begin
            $display("tb_noise_shaping_requantizer: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40ms;
        $display("tb_noise_shaping_requantizer: errors");
        $finish;
    end

endmodule

`default_nettype wire

### noise_shaping_requantizer.f
+incdir+hdl
hdl/nsr_pkg.sv
hdl/nsr_div.sv
hdl/nsr_ctrl.sv
hdl/nsr_datapath.sv
hdl/noise_shaping_requantizer.sv
sim/tb_noise_shaping_requantizer.sv
